### hw/rtl/sap_pkg.sv
// ----------------------------------------------------------------------------
// sap_pkg
// shared types, constants and the elaboration-time correction table builder
// for the softplus activation unit
// ----------------------------------------------------------------------------
package sap_pkg;

	localparam int X_W          = 16;
	localparam int Y_W          = 15;
	localparam int ROM_W        = 32;
	localparam int SPAN_LOG2    = 4;
	localparam int SEGMENTS_DEF = 64;
	localparam int FRAC_BITS_DEF = 8;

	localparam logic [Y_W-1:0]  Y_MAX   = {Y_W{1'b1}};
	localparam logic [63:0]     Q30_ONE = 64'd1 << 30;

	typedef struct packed {
		logic signed [X_W-1:0] x_value;
	} x_beat_t;

	typedef struct packed {
		logic [Y_W-1:0] y_value;
	} y_beat_t;

	// restoring shift-subtract divide, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-t), t in q30, as (exp(-t/32))^32
	function automatic logic [63:0] q30_exp_neg(input logic [63:0] t);
		logic [63:0] u;
		logic [63:0] term;
		longint      acc;
		logic [63:0] e;
		u    = t >> 5;
		term = Q30_ONE;
		acc  = longint'(Q30_ONE);
		for (int n = 1; n <= 20; n++) begin
			term = udiv64((term * u) >> 30, 64'(n));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		e = (acc < 0) ? 64'd0 : 64'(acc);
		for (int n = 0; n < 5; n++) begin
			e = (e * e) >> 30;
		end
		return e;
	endfunction

	// ln(1+z), z in q30, through 2*atanh(z/(2+z))
	function automatic logic [63:0] q30_log1p(input logic [63:0] z);
		logic [63:0] w;
		logic [63:0] w2;
		logic [63:0] p;
		logic [63:0] acc;
		w   = udiv64(z << 30, (Q30_ONE << 1) + z);
		w2  = (w * w) >> 30;
		p   = w;
		acc = '0;
		for (int n = 1; n < 40; n += 2) begin
			acc = acc + udiv64(p, 64'(n));
			p   = (p * w2) >> 30;
		end
		return acc << 1;
	endfunction

	// q2.30 sample of ln(1+exp(-t)) at t = 16*k/segs
	function automatic logic [ROM_W-1:0] rom_entry(input int k, input int segs);
		logic [63:0] t;
		logic [63:0] z;
		logic [63:0] c;
		t = udiv64(64'(k) << 34, 64'(segs));
		z = q30_exp_neg(t);
		if (z > Q30_ONE) begin
			z = Q30_ONE;
		end
		c = q30_log1p(z);
		return c[ROM_W-1:0];
	endfunction

endpackage

### hw/rtl/sap_stream_if.sv
// ----------------------------------------------------------------------------
// sap_stream_if
// valid/ready stream channel carrying one beat of a given payload type
// ----------------------------------------------------------------------------
interface sap_stream_if #(
	parameter type beat_t = logic
);
	logic  valid;
	logic  ready;
	beat_t data;

	modport source (
		output valid,
		output data,
		input  ready
	);

	modport sink (
		input  valid,
		input  data,
		output ready
	);
endinterface

### hw/rtl/sap_rom.sv
// ----------------------------------------------------------------------------
// sap_rom
// correction table with registered dual read of neighboring entries
// ----------------------------------------------------------------------------
module sap_rom #(
	parameter int SEGMENTS = sap_pkg::SEGMENTS_DEF,
	parameter int IDX_W    = $clog2(SEGMENTS + 1)
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [IDX_W-1:0]           idx,
	output logic [sap_pkg::ROM_W-1:0]  lo_s2,
	output logic [sap_pkg::ROM_W-1:0]  hi_s2
);
	import sap_pkg::*;

	logic [ROM_W-1:0] rom_w [SEGMENTS+1];

	for (genvar k = 0; k <= SEGMENTS; k++) begin : g_entry
		localparam logic [ROM_W-1:0] ENTRY = rom_entry(k, SEGMENTS);
		assign rom_w[k] = ENTRY;
	end

	// idx is clamped upstream to SEGMENTS-1, so idx+1 stays in range
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2 <= rom_w[idx];
			hi_s2 <= rom_w[idx + IDX_W'(1)];
		end
	end
endmodule

### hw/rtl/softplus_activation_unit.sv
// ----------------------------------------------------------------------------
// softplus_activation_unit
// streaming softplus y = max(x,0) + ln(1+exp(-|x|)) on q8.8 samples
// ----------------------------------------------------------------------------
// usage
//   sample : sink channel, one signed x_value per beat
//   result : source channel, one unsigned y_value per beat, in input order
//   every accepted sample yields exactly one result beat
// timing
//   four register stages: magnitude and segment index, table read,
//   slope multiply, interpolate/round/saturate
//   throughput is one beat per cycle while result.ready is high; the
//   slope multiply (32 x FRAC_BITS+4) and the table read each own a stage
//   and set the clock period
// reset
//   arst_n clears all stage valid bits at once; the pipeline comes up empty
//   and ready, payload registers are not reset
// backpressure
//   each stage holds while full and its successor cannot take a beat, so a
//   stall on result freezes only the occupied stages; bubbles ahead of a
//   stall still fill, and nothing is dropped or repeated
// ----------------------------------------------------------------------------
module softplus_activation_unit #(
	parameter int SEGMENTS  = sap_pkg::SEGMENTS_DEF,
	parameter int FRAC_BITS = sap_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sap_stream_if.sink   sample,
	sap_stream_if.source result
);
	import sap_pkg::*;

	// span of the table is 16 << FRAC_BITS, a power of two
	localparam int RW    = FRAC_BITS + SPAN_LOG2;
	localparam int IDX_W = $clog2(SEGMENTS + 1);
	localparam int SEG_W = $clog2(SEGMENTS + 1);
	localparam int A_W   = X_W + 1;
	localparam int S_W   = A_W + SEG_W;
	localparam int I_W   = S_W - RW;
	localparam int P_W   = ROM_W + RW;
	localparam int C_W   = FRAC_BITS + 2;
	localparam int SUM_W = Y_W + 2;

	localparam logic [A_W-1:0]   SPAN_TOP = A_W'(1) << RW;
	localparam logic [I_W-1:0]   IDX_LAST = I_W'(SEGMENTS - 1);
	localparam logic [ROM_W-1:0] RND      = ROM_W'(1) << (29 - FRAC_BITS);

	// stage handshake: a stage loads when empty or when its successor loads
	logic en_s1, en_s2, en_s3, en_s4;
	logic v_s1, v_s2, v_s3, v_s4;

	assign en_s4 = !v_s4 || result.ready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign sample.ready = en_s1;
	assign result.valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= sample.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// ---- stage 1: positive part, magnitude, range test, segment index and fraction
	logic signed [A_W-1:0] x_ext;
	logic [A_W-1:0]        a_mag;
	logic [S_W-1:0]        s_prod;
	logic [I_W-1:0]        i_raw;
	logic [IDX_W-1:0]      i_clamp;

	assign x_ext   = A_W'(sample.data.x_value);
	assign a_mag   = x_ext[A_W-1] ? A_W'(-x_ext) : A_W'(x_ext);
	assign s_prod  = S_W'(a_mag) * S_W'(SEGMENTS);
	assign i_raw   = s_prod[S_W-1:RW];
	assign i_clamp = (i_raw > IDX_LAST) ? IDX_W'(SEGMENTS - 1) : IDX_W'(i_raw);

	logic [Y_W-1:0]   xpos_s1;
	logic             rng_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [RW-1:0]    frac_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			// positive part; x > 0 never sets bit 15
			xpos_s1 <= (!sample.data.x_value[X_W-1]) ? sample.data.x_value[Y_W-1:0] : '0;
			rng_s1  <= a_mag < SPAN_TOP;
			idx_s1  <= i_clamp;
			frac_s1 <= s_prod[RW-1:0];
		end
	end

	// ---- stage 2: table read of both neighbors
	logic [ROM_W-1:0] lo_s2, hi_s2;
	logic [Y_W-1:0]   xpos_s2;
	logic             rng_s2;
	logic [RW-1:0]    frac_s2;

	sap_rom #(
		.SEGMENTS (SEGMENTS),
		.IDX_W    (IDX_W)
	) u_rom (
		.clk   (clk),
		.en    (en_s2),
		.idx   (idx_s1),
		.lo_s2 (lo_s2),
		.hi_s2 (hi_s2)
	);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			xpos_s2 <= xpos_s1;
			rng_s2  <= rng_s1;
			frac_s2 <= frac_s1;
		end
	end

	// ---- stage 3: slope magnitude times fraction
	logic             desc;
	logic [ROM_W-1:0] delta;

	assign desc  = lo_s2 >= hi_s2;
	assign delta = desc ? (lo_s2 - hi_s2) : (hi_s2 - lo_s2);

	logic [P_W-1:0]   prod_s3;
	logic [ROM_W-1:0] lo_s3;
	logic             desc_s3;
	logic [Y_W-1:0]   xpos_s3;
	logic             rng_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			prod_s3 <= P_W'(delta) * P_W'(frac_s2);
			lo_s3   <= lo_s2;
			desc_s3 <= desc;
			xpos_s3 <= xpos_s2;
			rng_s3  <= rng_s2;
		end
	end

	// ---- stage 4: interpolate, round half up, add, saturate
	logic [ROM_W-1:0] step;
	logic [ROM_W-1:0] c_interp;
	logic [ROM_W-1:0] c_round;
	logic [C_W-1:0]   corr;
	logic [SUM_W-1:0] y_sum;

	assign step     = ROM_W'(prod_s3 >> RW);
	assign c_interp = desc_s3 ? (lo_s3 - step) : (lo_s3 + step);
	assign c_round  = c_interp + RND;
	assign corr     = rng_s3 ? C_W'(c_round >> (30 - FRAC_BITS)) : '0;
	assign y_sum    = SUM_W'(xpos_s3) + SUM_W'(corr);

	logic [Y_W-1:0] y_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			y_s4 <= (y_sum > SUM_W'(Y_MAX)) ? Y_MAX : y_sum[Y_W-1:0];
		end
	end

	assign result.data.y_value = y_s4;
endmodule

### hw/rtl/sap_checker.sv
// ----------------------------------------------------------------------------
// sap_checker
// port-level timing checks for the softplus activation unit, bound to the top
// ----------------------------------------------------------------------------
module sap_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [sap_pkg::Y_W-1:0]   y_value
);
	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(y_value))
		else $error("result beat changed while stalled");

	// an open output never blocks the input side
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output ready");

	// result reaches the output through stages 2, 3 and 4 when the receiver keeps taking beats
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result missing four cycles after accept");

	// pipeline empty once reset has been seen at an edge
	a_rst: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid after reset");
endmodule

bind softplus_activation_unit sap_checker u_sap_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.y_value   (result.data.y_value)
);
